/* hw/rtl/mpe_pkg.sv */
// ----------------------------------------------------------------------------
// mpe_pkg
// Shared types, constants and letter helpers of the phonetic encoder.
// ----------------------------------------------------------------------------
package mpe_pkg;

    // letter class flag bit positions
    localparam int unsigned CL_VOWEL = 0;
    localparam int unsigned CL_SAME  = 1;
    localparam int unsigned CL_AFFH  = 2;
    localparam int unsigned CL_SOFT  = 3;
    localparam int unsigned CL_NOGH  = 4;

    localparam logic [4:0] CLASS_TAB [26] = '{
        5'd1, 5'd16, 5'd4, 5'd16, 5'd9, 5'd2, 5'd4, 5'd16, 5'd9, 5'd2,
        5'd0, 5'd2, 5'd2, 5'd2, 5'd1, 5'd4, 5'd0, 5'd2, 5'd4, 5'd4,
        5'd1, 5'd0, 5'd0, 5'd0, 5'd8, 5'd0
    };

    localparam logic [7:0] CODE_SH = 8'h58;  // X
    localparam logic [7:0] CODE_TH = 8'h30;  // 0

    // configuration register indexes
    localparam logic CFG_MAX_CODES = 1'b0;
    localparam logic CFG_TRAD_MODE = 1'b1;

    typedef struct packed {
        logic [7:0] max_codes;
        logic       trad;
    } t_cfg;

    // one queue entry: one or two code letters of a position, or a word end
    typedef struct packed {
        logic       is_end;
        logic       term;
        logic       empty;
        logic       two;
        logic [7:0] c0;
        logic [7:0] c1;
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_END
    } t_fe_state;

    function automatic logic [7:0] fold(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7a) begin
            return c - 8'd32;
        end
        return c;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic [4:0] cls(input logic [7:0] c);
        logic [7:0] d;
        d = c - 8'h41;
        if (is_letter(c)) begin
            return CLASS_TAB[d[4:0]];
        end
        return 5'd0;
    endfunction

endpackage

/* hw/rtl/mpe_front.sv */
// ----------------------------------------------------------------------------
// mpe_front
// Takes bytes, keeps the letter window and codes each position into ops.
// ----------------------------------------------------------------------------
module mpe_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mpe_pkg::t_cfg i_cfg,
    input  logic          push,
    input  logic [7:0]    i_char_code,
    output logic          full,
    input  logic          i_q_full,
    output logic          o_q_push,
    output mpe_pkg::t_op  o_q_op
);
    import mpe_pkg::*;

    t_fe_state   r_state, n_state;
    logic [7:0]  r_win [8];
    logic [8:0]  r_cnt;
    logic        r_fld;
    logic [1:0]  r_skip;
    logic [2:0]  r_seen;
    logic [1:0]  r_fcnt;

    logic [7:0]  b_fold;
    logic [7:0]  w_sh [8];
    logic [2:0]  seen_n;
    logic        acc;
    logic        apply;
    logic        step_flush;
    logic        step_end;

    logic [7:0]  cur, nx, an, a3, pv;
    logic [4:0]  c_cur, c_nx, c_an, c_pv, c_w1;
    logic [1:0]  cp_n;
    logic [7:0]  cp_c0, cp_c1;
    logic [1:0]  cp_skip;
    logic        cp_fld;
    logic [8:0]  cp_cnt;
    logic [9:0]  cnt_sum;
    logic        done;

    // handshake and step selection
    assign b_fold     = fold(i_char_code);
    assign full       = (r_state != ST_IDLE) || i_q_full;
    assign acc        = push && !full;
    assign seen_n     = (r_seen < 3'd4) ? r_seen + 3'd1 : r_seen;
    assign step_flush = (r_state == ST_FLUSH) && !i_q_full;
    assign step_end   = (r_state == ST_END) && !i_q_full;
    assign apply      = (acc && b_fold != 8'd0 && seen_n >= 3'd4)
                      || (step_flush && w_sh[4] != 8'd0);

    // window after the shift of this step
    always_comb begin
        for (int i = 0; i < 7; i++) begin
            w_sh[i] = r_win[i+1];
        end
        w_sh[7] = (r_state == ST_IDLE) ? b_fold : 8'd0;
    end

    // coding of the current position
    always_comb begin
        cur   = w_sh[4];
        nx    = w_sh[5];
        an    = (nx != 8'd0) ? w_sh[6] : 8'd0;
        a3    = (nx != 8'd0 && w_sh[6] != 8'd0) ? w_sh[7] : 8'd0;
        pv    = w_sh[3];
        c_cur = cls(cur);
        c_nx  = cls(nx);
        c_an  = cls(an);
        c_pv  = cls(pv);
        c_w1  = cls(w_sh[1]);
        cp_n    = 2'd0;
        cp_c0   = 8'd0;
        cp_c1   = 8'd0;
        cp_skip = r_skip;
        cp_fld  = r_fld;
        done    = 1'b0;
        if (r_skip != 2'd0) begin
            cp_skip = r_skip - 2'd1;
            done    = 1'b1;
        end else if (!r_fld) begin
            if (!is_letter(cur)) begin
                done = 1'b1;
            end else begin
                cp_fld = 1'b1;
                case (cur)
                    "A": begin
                        cp_n = 2'd1;
                        done = 1'b1;
                        if (nx == "E") begin
                            cp_c0   = "E";
                            cp_skip = 2'd1;
                        end else begin
                            cp_c0 = "A";
                        end
                    end
                    "G", "K", "P": begin
                        if (nx == "N") begin
                            cp_n    = 2'd1;
                            cp_c0   = "N";
                            cp_skip = 2'd1;
                            done    = 1'b1;
                        end
                    end
                    "W": begin
                        if (nx == "H" || nx == "R") begin
                            cp_n    = 2'd1;
                            cp_c0   = nx;
                            cp_skip = 2'd1;
                            done    = 1'b1;
                        end else if (c_nx[CL_VOWEL]) begin
                            cp_n    = 2'd1;
                            cp_c0   = "W";
                            cp_skip = 2'd1;
                            done    = 1'b1;
                        end
                    end
                    "X": begin
                        cp_n  = 2'd1;
                        cp_c0 = "S";
                        done  = 1'b1;
                    end
                    "E", "I", "O", "U": begin
                        cp_n  = 2'd1;
                        cp_c0 = cur;
                        done  = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
        if (!done) begin
            if ((i_cfg.max_codes != 8'd0 && r_cnt >= {1'b0, i_cfg.max_codes})
                || !is_letter(cur) || (cur == pv && cur != "C")) begin
                done = 1'b1;
            end
        end
        if (!done) begin
            cp_n = 2'd1;
            case (cur)
                "B": begin
                    cp_c0 = "B";
                    if (pv == "M") cp_n = 2'd0;
                end
                "C": begin
                    if (c_nx[CL_SOFT]) begin
                        if (an == "A" && nx == "I") cp_c0 = CODE_SH;
                        else if (pv != "S") cp_c0 = "S";
                        else cp_n = 2'd0;
                    end else if (nx == "H") begin
                        if (!i_cfg.trad && (an == "R" || pv == "S")) cp_c0 = "K";
                        else cp_c0 = CODE_SH;
                        cp_skip = 2'd1;
                    end else begin
                        cp_c0 = "K";
                    end
                end
                "D": begin
                    if (nx == "G" && c_an[CL_SOFT]) begin
                        cp_c0   = "J";
                        cp_skip = 2'd1;
                    end else begin
                        cp_c0 = "T";
                    end
                end
                "G": begin
                    if (nx == "H") begin
                        if (!(c_w1[CL_NOGH] || w_sh[0] == "H")) begin
                            cp_c0   = "F";
                            cp_skip = 2'd1;
                        end else begin
                            cp_n = 2'd0;
                        end
                    end else if (nx == "N") begin
                        cp_c0 = "K";
                        if (!is_letter(an) || (an == "E" && a3 == "D")) cp_n = 2'd0;
                    end else if (c_nx[CL_SOFT] && pv != "G") begin
                        cp_c0 = "J";
                    end else begin
                        cp_c0 = "K";
                    end
                end
                "H": begin
                    cp_c0 = "H";
                    if (!(c_nx[CL_VOWEL] && !c_pv[CL_AFFH])) cp_n = 2'd0;
                end
                "K": begin
                    cp_c0 = "K";
                    if (pv == "C") cp_n = 2'd0;
                end
                "P": cp_c0 = (nx == "H") ? "F" : "P";
                "Q": cp_c0 = "K";
                "S": begin
                    if (nx == "I" && (an == "O" || an == "A")) begin
                        cp_c0 = CODE_SH;
                    end else if (nx == "H") begin
                        cp_c0   = CODE_SH;
                        cp_skip = 2'd1;
                    end else if (!i_cfg.trad && nx == "C" && an == "H" && a3 == "W") begin
                        cp_c0   = CODE_SH;
                        cp_skip = 2'd2;
                    end else begin
                        cp_c0 = "S";
                    end
                end
                "T": begin
                    if (nx == "I" && (an == "O" || an == "A")) begin
                        cp_c0 = CODE_SH;
                    end else if (nx == "H") begin
                        cp_c0   = CODE_TH;
                        cp_skip = 2'd1;
                    end else begin
                        cp_c0 = "T";
                    end
                end
                "V": cp_c0 = "F";
                "W", "Y": begin
                    cp_c0 = cur;
                    if (!c_nx[CL_VOWEL]) cp_n = 2'd0;
                end
                "X": begin
                    cp_n  = 2'd2;
                    cp_c0 = "K";
                    cp_c1 = "S";
                end
                "Z": cp_c0 = "S";
                default: begin
                    cp_c0 = cur;
                    if (!c_cur[CL_SAME]) cp_n = 2'd0;
                end
            endcase
        end
        // saturating code count
        cnt_sum = {1'b0, r_cnt} + {8'd0, cp_n};
        cp_cnt  = cnt_sum[9] ? 9'd511 : cnt_sum[8:0];
    end

    // queue write
    assign o_q_push     = (apply && cp_n != 2'd0) || step_end;
    assign o_q_op.is_end = step_end;
    assign o_q_op.term  = (r_state == ST_FLUSH);
    assign o_q_op.empty = (r_cnt == 9'd0);
    assign o_q_op.two   = (cp_n == 2'd2);
    assign o_q_op.c0    = cp_c0;
    assign o_q_op.c1    = cp_c1;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (acc && b_fold == 8'd0) n_state = ST_FLUSH;
            ST_FLUSH: if (step_flush && r_fcnt == 2'd2) n_state = ST_END;
            ST_END:   if (step_end) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // window and per-word state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || step_end) begin
            for (int i = 0; i < 8; i++) begin
                r_win[i] <= 8'd0;
            end
            r_cnt  <= 9'd0;
            r_fld  <= 1'b0;
            r_skip <= 2'd0;
            r_seen <= 3'd0;
            r_fcnt <= 2'd0;
        end else begin
            if ((acc && b_fold != 8'd0) || step_flush) begin
                r_win <= w_sh;
            end
            if (acc && b_fold != 8'd0) begin
                r_seen <= seen_n;
            end
            if (acc && b_fold == 8'd0) begin
                r_fcnt <= 2'd0;
            end else if (step_flush) begin
                r_fcnt <= r_fcnt + 2'd1;
            end
            if (apply) begin
                r_cnt  <= cp_cnt;
                r_fld  <= cp_fld;
                r_skip <= cp_skip;
            end
        end
    end

endmodule

/* hw/rtl/mpe_queue.sv */
// ----------------------------------------------------------------------------
// mpe_queue
// Small register queue of coded ops between front and back.
// ----------------------------------------------------------------------------
module mpe_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  mpe_pkg::t_op i_op,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output mpe_pkg::t_op o_op
);
    import mpe_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_op              r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/mpe_back.sv */
// ----------------------------------------------------------------------------
// mpe_back
// Turns queued ops into single result beats and marks the word end.
// ----------------------------------------------------------------------------
module mpe_back (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_valid,
    input  mpe_pkg::t_op i_q_op,
    output logic         o_q_pop,
    output logic         empty,
    input  logic         pop,
    output logic [7:0]   o_code_letter,
    output logic         o_is_last,
    output logic         o_is_empty
);
    import mpe_pkg::*;

    logic       r_sub;
    logic       r_hold_v;
    logic [7:0] r_hold_c;
    logic       r_ov;
    logic [7:0] r_oc;
    logic       r_olast, r_oempty;

    logic       go;
    logic [7:0] letter;
    logic       last_code;
    logic       produce;
    logic [7:0] p_c;
    logic       p_last, p_empty;

    assign empty         = !r_ov;
    assign o_code_letter = r_oc;
    assign o_is_last     = r_olast;
    assign o_is_empty    = r_oempty;

    assign go        = i_q_valid && (!r_ov || pop);
    assign letter    = r_sub ? i_q_op.c1 : i_q_op.c0;
    assign last_code = !i_q_op.two || r_sub;
    assign o_q_pop   = go && (i_q_op.is_end || last_code);

    // choose the beat of this cycle
    always_comb begin
        produce = 1'b0;
        p_c     = 8'd0;
        p_last  = 1'b0;
        p_empty = 1'b0;
        if (go) begin
            if (i_q_op.is_end) begin
                produce = 1'b1;
                p_last  = 1'b1;
                if (r_hold_v) begin
                    p_c = r_hold_c;
                end else begin
                    p_empty = i_q_op.empty;
                end
            end else if (!i_q_op.term) begin
                produce = 1'b1;
                p_c     = letter;
            end else if (r_hold_v) begin
                produce = 1'b1;
                p_c     = r_hold_c;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (produce) begin
            r_ov <= 1'b1;
        end else if (pop) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_oc     <= p_c;
            r_olast  <= p_last;
            r_oempty <= p_empty;
        end
    end

    // code index and held code of the word end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub    <= 1'b0;
            r_hold_v <= 1'b0;
        end else if (go) begin
            r_sub <= !i_q_op.is_end && !last_code;
            if (i_q_op.is_end) begin
                r_hold_v <= 1'b0;
            end else if (i_q_op.term) begin
                r_hold_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && !i_q_op.is_end && i_q_op.term) begin
            r_hold_c <= letter;
        end
    end

endmodule

/* hw/rtl/metaphone_phonetic_encoder.sv */
// ----------------------------------------------------------------------------
// metaphone_phonetic_encoder
// Streaming Metaphone coder: bytes in, code letters out.
// ----------------------------------------------------------------------------
// A nonzero byte is taken whenever the front is idle and the op queue has
// room; the front codes the letter three places back in that same cycle. A
// zero byte closes the word and holds full while the front shifts out the
// three tail positions and queues the word end. The back delivers one code
// letter per cycle while pop takes them, so a two-code letter (X) gives two
// code letters; the end marker or the last code of the word carries is_last.
module metaphone_phonetic_encoder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_char_code,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_code_letter,
    output logic       o_is_last,
    output logic       o_is_empty
);
    import mpe_pkg::*;

    t_cfg r_cfg;
    logic q_push, q_full, q_pop, q_valid;
    t_op  q_in, q_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_CODES: r_cfg.max_codes <= i_cfg_data;
                CFG_TRAD_MODE: r_cfg.trad      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    mpe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .push        (push),
        .i_char_code (i_char_code),
        .full        (full),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_op      (q_in)
    );

    mpe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_op    (q_out)
    );

    mpe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_op        (q_out),
        .o_q_pop       (q_pop),
        .empty         (empty),
        .pop           (pop),
        .o_code_letter (o_code_letter),
        .o_is_last     (o_is_last),
        .o_is_empty    (o_is_empty)
    );

    // front never writes a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full)) else $error("op queue overflow");

    // an empty word gives only the end marker
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_is_empty) |-> (o_is_last && o_code_letter == 8'd0))
        else $error("empty word marker malformed");

    // input side is held off while the queue is full
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> full) else $error("input taken with queue full");

endmodule
